FILE: rtl/rhdc_pkg.sv
// Shared types and constants for the recent-hash dedup cache.
// Used by the ring memory, the scan controller and the top level.
package rhdc_pkg;

  localparam int HASH_W   = 64;
  localparam int DEPTH_W  = 7;
  localparam int HEADER_W = 8;

  localparam int CACHED_BIT = 7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } rhdc_state_t;

endpackage

FILE: rtl/rhdc_ring.sv
// Ring memory of stored hashes: one write port and one registered read port.
// Depends on rhdc_pkg for the hash width.
module rhdc_ring import rhdc_pkg::*; #(
  parameter int CACHE_ENTRIES = 256,
  parameter int PTR_W         = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [PTR_W-1:0]  rd_addr,
  output logic [HASH_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [PTR_W-1:0]  wr_addr,
  input  logic [HASH_W-1:0] wr_data
);

  logic [HASH_W-1:0] mem [CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/rhdc_ctrl.sv
// Scan controller: walks the filled ring entries newest first, compares,
// and inserts the hash on a miss. Depends on rhdc_pkg and drives rhdc_ring.
module rhdc_ctrl import rhdc_pkg::*; #(
  parameter int CACHE_ENTRIES = 256,
  parameter int PTR_W         = 8,
  parameter int CNT_W         = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [HASH_W-1:0]   record_hash,
  input  logic [DEPTH_W-1:0]  record_depth,
  output logic                done,
  output logic [HEADER_W-1:0] header_byte,
  output logic [HASH_W-1:0]   hash_out,
  output logic                was_cached,
  output logic                rd_en,
  output logic [PTR_W-1:0]    rd_addr,
  input  logic [HASH_W-1:0]   rd_data,
  output logic                wr_en,
  output logic [PTR_W-1:0]    wr_addr,
  output logic [HASH_W-1:0]   wr_data
);

  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

  rhdc_state_t state, state_next;

  logic [HASH_W-1:0]  key;
  logic [DEPTH_W-1:0] depth;
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic [PTR_W-1:0]   scan_pos, scan_pos_next;
  logic [CNT_W-1:0]   left, left_next;
  logic               pend, pend_next;
  logic               hit_flag, hit_flag_next;
  logic               done_next;
  logic               accept;
  logic               hit;
  logic               finish;
  logic [PTR_W-1:0]   prev_pos;

  assign accept   = (state == ST_IDLE) && start;
  assign hit      = pend && (rd_data == key);
  assign finish   = (state == ST_SCAN) && (hit || (left == '0));
  assign prev_pos = (scan_pos == '0) ? LAST_POS : scan_pos - PTR_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en              = 1'b0;
    rd_addr            = prev_pos;
    wr_en              = 1'b0;
    wr_addr            = write_pointer;
    wr_data            = key;
    write_pointer_next = write_pointer;
    fill_count_next    = fill_count;
    scan_pos_next      = scan_pos;
    left_next          = left;
    pend_next          = 1'b0;
    hit_flag_next      = hit_flag;
    done_next          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        scan_pos_next = write_pointer;
        left_next     = fill_count;
      end
      ST_SCAN: begin
        if (finish) begin
          done_next     = 1'b1;
          hit_flag_next = hit;
          if (!hit) begin
            wr_en              = 1'b1;
            write_pointer_next = (write_pointer == LAST_POS) ? '0
                                 : write_pointer + PTR_W'(1);
            if (fill_count != FULL_CNT) begin
              fill_count_next = fill_count + CNT_W'(1);
            end
          end
        end else begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          scan_pos_next = prev_pos;
          left_next     = left - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      fill_count    <= '0;
      pend          <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      write_pointer <= write_pointer_next;
      fill_count    <= fill_count_next;
      pend          <= pend_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_pos <= scan_pos_next;
    left     <= left_next;
    hit_flag <= hit_flag_next;
    if (accept) begin
      key   <= record_hash;
      depth <= record_depth;
    end
  end

  assign busy        = (state != ST_IDLE);
  assign hash_out    = key;
  assign was_cached  = hit_flag;
  assign header_byte = {hit_flag, depth};

endmodule

FILE: rtl/recent_hash_dedup_cache.sv
// Recent-hash dedup cache: one request at a time, scanned against a FIFO ring.
// done rises after the scan, which compares N entries (up to the fill count,
// at most CACHE_ENTRIES), one per cycle through the ring memory's single read
// port; busy stays high until then. Reset empties the ring by clearing the
// write pointer and fill count; stored hashes are not cleared.
module recent_hash_dedup_cache import rhdc_pkg::*; #(
  parameter int CACHE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [HASH_W-1:0]   record_hash,
  input  logic [DEPTH_W-1:0]  record_depth,
  output logic                done,
  output logic [HEADER_W-1:0] header_byte,
  output logic [HASH_W-1:0]   hash_out,
  output logic                was_cached
);

  localparam int PTR_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [HASH_W-1:0] rd_data;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [HASH_W-1:0] wr_data;

  rhdc_ctrl #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PTR_W         (PTR_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .record_hash  (record_hash),
    .record_depth (record_depth),
    .done         (done),
    .header_byte  (header_byte),
    .hash_out     (hash_out),
    .was_cached   (was_cached),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  rhdc_ring #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PTR_W         (PTR_W)
  ) u_ring (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for recent_hash_dedup_cache: sends lookup requests through start/busy and
// checks every done result against a ring predictor kept in the testbench.
// Depends on rhdc_pkg and the recent_hash_dedup_cache RTL.
module testbench;
  import rhdc_pkg::*;

  localparam int RING_ENTRIES = 256;
  localparam int RANDOM_COUNT = 830;
  localparam int CALM_TAIL = 100;
  localparam int SETTLE_CYCLES = RING_ENTRIES + 40;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [HASH_W-1:0]  hash;
    logic [DEPTH_W-1:0] depth;
    bit                 drain_first;
  } lookup_req_t;

  typedef struct {
    logic [HEADER_W-1:0] header;
    logic [HASH_W-1:0]   hash;
    logic                cached;
  } lookup_res_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [HASH_W-1:0]   record_hash = '0;
  logic [DEPTH_W-1:0]  record_depth = '0;
  logic                busy;
  logic                done;
  logic [HEADER_W-1:0] header_byte;
  logic [HASH_W-1:0]   hash_out;
  logic                was_cached;

  lookup_req_t       pending_q[$];
  lookup_res_t       expected_q[$];
  logic [HASH_W-1:0] sent_hashes[$];
  logic [HASH_W-1:0] ring_model [RING_ENTRIES];
  int unsigned       wr_ptr_model = 0;
  int unsigned       fill_model = 0;
  int unsigned       accepted_count = 0;
  int unsigned       total_count = 0;
  int unsigned       gap_left = 0;
  int unsigned       fail_count = 0;
  longint unsigned   cycle_count = 0;

  always #5 clk = ~clk;

  recent_hash_dedup_cache #(
    .CACHE_ENTRIES(RING_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .record_hash(record_hash),
    .record_depth(record_depth),
    .done(done),
    .header_byte(header_byte),
    .hash_out(hash_out),
    .was_cached(was_cached)
  );

  // Searches the filled part of the ring newest first and inserts on a miss.
  function automatic lookup_res_t predict_lookup(logic [HASH_W-1:0] h,
                                                 logic [DEPTH_W-1:0] d);
    lookup_res_t res;
    int unsigned pos;
    bit          hit;
    pos = wr_ptr_model;
    hit = 1'b0;
    for (int unsigned k = 0; k < fill_model && !hit; k++) begin
      pos = (pos == 0) ? RING_ENTRIES - 1 : pos - 1;
      if (ring_model[pos] === h) hit = 1'b1;
    end
    if (!hit) begin
      ring_model[wr_ptr_model] = h;
      wr_ptr_model = (wr_ptr_model + 1) % RING_ENTRIES;
      if (fill_model < RING_ENTRIES) fill_model++;
    end
    res.header = {hit, d};
    res.hash = h;
    res.cached = hit;
    return res;
  endfunction

  function automatic void queue_lookup(logic [HASH_W-1:0] h, logic [DEPTH_W-1:0] d,
                                       bit drain);
    lookup_req_t req;
    req.hash = h;
    req.depth = d;
    req.drain_first = drain;
    pending_q.push_back(req);
    sent_hashes.push_back(h);
  endfunction

  // Mostly fresh hashes and repeats of recent ones, plus old, near and corner hashes.
  function automatic logic [HASH_W-1:0] pick_hash();
    int unsigned       roll;
    int unsigned       n;
    logic [HASH_W-1:0] h;
    roll = $urandom_range(0, 99);
    n = sent_hashes.size();
    if (roll < 45 || n == 0) begin
      h = {$urandom, $urandom};
    end else if (roll < 75) begin
      h = sent_hashes[n - 1 - $urandom_range(0, ((n < 64) ? n : 64) - 1)];
    end else if (roll < 85) begin
      h = sent_hashes[$urandom_range(0, n - 1)];
    end else if (roll < 95) begin
      h = sent_hashes[$urandom_range(0, n - 1)];
      h[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
    end else if (roll < 98) begin
      h = {{(HASH_W-1){1'b0}}, 1'b1} << $urandom_range(0, HASH_W - 1);
    end else if (roll == 98) begin
      h = '0;
    end else begin
      h = '1;
    end
    return h;
  endfunction

  always @(posedge clk) begin
    bit          taken;
    bit          ready;
    logic        next_start;
    lookup_req_t req;
    taken = start && !busy;
    next_start = start && !taken;
    if (rst) begin
      next_start = 1'b0;
    end else begin
      if (taken) begin
        expected_q.push_back(predict_lookup(record_hash, record_depth));
        req = pending_q.pop_front();
        accepted_count++;
        if ((accepted_count / 40) % 2 == 0 && accepted_count + CALM_TAIL < total_count &&
            $urandom_range(0, 2) == 0) begin
          gap_left = $urandom_range(1, 10);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          req = pending_q[0];
          ready = !req.drain_first || (expected_q.size() == 0 && !done && !busy);
          if (ready) begin
            next_start = 1'b1;
            record_hash <= req.hash;
            record_depth <= req.depth;
          end
        end
      end
    end
    start <= next_start;
  end

  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hash %h header %h cached %b",
                 $time, hash_out, header_byte, was_cached);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (header_byte !== want.header) begin
          $display("%0t: header_byte expected %h actual %h", $time, want.header, header_byte);
          fail_count++;
        end
        if (hash_out !== want.hash) begin
          $display("%0t: hash_out expected %h actual %h", $time, want.hash, hash_out);
          fail_count++;
        end
        if (was_cached !== want.cached) begin
          $display("%0t: was_cached expected %b actual %b", $time, want.cached, was_cached);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    // A zero hash must miss on the empty ring, then hit.
    queue_lookup(64'h0, 7'd0, 1'b0);
    queue_lookup(64'h0, 7'd127, 1'b0);
    queue_lookup('1, 7'd127, 1'b0);
    queue_lookup('1, 7'd0, 1'b0);
    queue_lookup(64'h8000_0000_0000_0000, 7'd1, 1'b0);
    queue_lookup(64'h0000_0000_0000_0001, 7'd64, 1'b0);
    queue_lookup(64'hAAAA_AAAA_AAAA_AAAA, 7'h55, 1'b0);
    queue_lookup(64'h5555_5555_5555_5555, 7'h2A, 1'b0);
    queue_lookup(64'hAAAA_AAAA_AAAA_AAAB, 7'h7F, 1'b0);
    queue_lookup(64'h0, 7'd3, 1'b1);
    queue_lookup(64'h8000_0000_0000_0000, 7'd126, 1'b0);
    queue_lookup(64'h5555_5555_5555_5555, 7'h00, 1'b0);
    queue_lookup(64'h5555_5555_5555_5555, 7'h7F, 1'b0);
    queue_lookup(64'h7FFF_FFFF_FFFF_FFFF, 7'd9, 1'b0);
    queue_lookup(64'hFFFF_FFFF_FFFF_FFFE, 7'd10, 1'b0);
    queue_lookup(64'h0000_0001_0000_0000, 7'd11, 1'b0);
    queue_lookup(64'h0000_0000_8000_0000, 7'd12, 1'b0);
    queue_lookup(64'h0000_0001_0000_0000, 7'd13, 1'b0);
    queue_lookup('1, 7'd14, 1'b0);
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      queue_lookup(pick_hash(), 7'($urandom_range(0, 127)), i == RANDOM_COUNT / 2);
    end
    total_count = pending_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
